@@ rtl/assert_macros.svh @@
// assertion macros for the rdc rtl files
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge, off while reset is asserted
`define RDC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rdc assertion failed");

// check on every rising edge, reset included
`define RDC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("rdc assertion failed");

`endif

@@ rtl/rdc_pkg.sv @@
// widths, register indexes and stage interface types for the ray to display block
// no dependencies
`default_nettype none

package rdc_pkg;

    localparam int CORD_W        = 20;
    localparam int DIR_W         = 18;
    localparam int CFG_W         = 3 * CORD_W;
    localparam int CFG_IDX_W     = 2;
    localparam int EDGE_W        = CORD_W + 1;
    localparam int PROD_W        = EDGE_W + DIR_W;
    localparam int CROSS_W       = PROD_W + 1;
    localparam int SPLIT_W       = CROSS_W / 2;
    localparam int HI_W          = EDGE_W + (CROSS_W - SPLIT_W);
    localparam int LO_W          = EDGE_W + SPLIT_W + 1;
    localparam int DOT_W         = 61;
    localparam int MAG_W         = DOT_W - 1;
    localparam int OUT_W         = 24;
    localparam int QB            = OUT_W + 1;
    localparam int RW            = MAG_W + QB;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LR = 2'd2;

    // cyclic neighbors for cross product components
    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};

    typedef struct packed {
        logic                    valid;
        logic signed [DOT_W-1:0] num;
        logic signed [DOT_W-1:0] den;
    } t_quot_req;

    typedef struct packed {
        logic                    valid;
        logic                    zero;
        logic                    sat;
        logic signed [OUT_W-1:0] coord;
    } t_div_res;

    typedef struct packed {
        logic signed [OUT_W-1:0] coord_u;
        logic signed [OUT_W-1:0] coord_v;
        logic                    degenerate;
        logic                    saturated;
    } t_out_word;

endpackage

`default_nettype wire

@@ rtl/rdc_geom.sv @@
// six-stage determinant pipeline: edges, cross products, split dot products
// depends on rdc_pkg
`default_nettype none

module rdc_geom (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_en,
    input  wire                              i_valid,
    input  wire  [rdc_pkg::CFG_W-1:0]        i_ll,
    input  wire  [rdc_pkg::CFG_W-1:0]        i_ul,
    input  wire  [rdc_pkg::CFG_W-1:0]        i_lr,
    input  wire  signed [rdc_pkg::CORD_W-1:0] i_origin_x,
    input  wire  signed [rdc_pkg::CORD_W-1:0] i_origin_y,
    input  wire  signed [rdc_pkg::CORD_W-1:0] i_origin_z,
    input  wire  signed [rdc_pkg::DIR_W-1:0] i_dir_x,
    input  wire  signed [rdc_pkg::DIR_W-1:0] i_dir_y,
    input  wire  signed [rdc_pkg::DIR_W-1:0] i_dir_z,
    output rdc_pkg::t_quot_req               o_req_u,
    output rdc_pkg::t_quot_req               o_req_v
);
    import rdc_pkg::*;

    logic signed [CORD_W-1:0]  w_org [3];
    logic signed [DIR_W-1:0]   w_dir [3];

    logic                      r_v [1:6];
    logic signed [EDGE_W-1:0]  r1_e2 [3], r1_e3 [3], r1_p [3];
    logic signed [DIR_W-1:0]   r1_d [3];
    logic signed [PROD_W-1:0]  r2_pa [3][2], r2_pb [3][2];
    logic signed [EDGE_W-1:0]  r2_p [3], r2_e2 [3], r3_p [3], r3_e2 [3];
    logic signed [CROSS_W-1:0] r3_ca [3], r3_cb [3];
    // dot index: 0 = P.cA (u), 1 = P.cB (v), 2 = E2.cB (den)
    logic signed [HI_W-1:0]    r4_hi [3][3];
    logic signed [LO_W-1:0]    r4_lo [3][3];
    logic signed [DOT_W-1:0]   r5_t [3][3];
    logic signed [DOT_W-1:0]   r6_sum [3];

    assign w_org[0] = i_origin_x;
    assign w_org[1] = i_origin_y;
    assign w_org[2] = i_origin_z;
    assign w_dir[0] = i_dir_x;
    assign w_dir[1] = i_dir_y;
    assign w_dir[2] = i_dir_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= 6; s++) r_v[s] <= 1'b0;
        end else if (i_en) begin
            r_v[1] <= i_valid;
            for (int s = 2; s <= 6; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                // stage 1: edge vectors and origin relative to lower-left
                r1_e2[i] <= EDGE_W'($signed(i_ul[CORD_W*i +: CORD_W]))
                          - EDGE_W'($signed(i_ll[CORD_W*i +: CORD_W]));
                r1_e3[i] <= EDGE_W'($signed(i_lr[CORD_W*i +: CORD_W]))
                          - EDGE_W'($signed(i_ll[CORD_W*i +: CORD_W]));
                r1_p[i]  <= EDGE_W'(w_org[i])
                          - EDGE_W'($signed(i_ll[CORD_W*i +: CORD_W]));
                r1_d[i]  <= w_dir[i];
                // stage 2: cross product terms, cA = d x E2, cB = E3 x d
                r2_pa[i][0] <= PROD_W'(r1_d[NXT[i]] * r1_e2[PRV[i]]);
                r2_pa[i][1] <= PROD_W'(r1_d[PRV[i]] * r1_e2[NXT[i]]);
                r2_pb[i][0] <= PROD_W'(r1_e3[NXT[i]] * r1_d[PRV[i]]);
                r2_pb[i][1] <= PROD_W'(r1_e3[PRV[i]] * r1_d[NXT[i]]);
                r2_p[i]  <= r1_p[i];
                r2_e2[i] <= r1_e2[i];
                // stage 3: cross product components
                r3_ca[i] <= CROSS_W'(r2_pa[i][0]) - CROSS_W'(r2_pa[i][1]);
                r3_cb[i] <= CROSS_W'(r2_pb[i][0]) - CROSS_W'(r2_pb[i][1]);
                r3_p[i]  <= r2_p[i];
                r3_e2[i] <= r2_e2[i];
                // stage 4: partial products on split cross components
                r4_hi[0][i] <= HI_W'(r3_p[i] * $signed(r3_ca[i][CROSS_W-1:SPLIT_W]));
                r4_lo[0][i] <= LO_W'(r3_p[i] * $signed({1'b0, r3_ca[i][SPLIT_W-1:0]}));
                r4_hi[1][i] <= HI_W'(r3_p[i] * $signed(r3_cb[i][CROSS_W-1:SPLIT_W]));
                r4_lo[1][i] <= LO_W'(r3_p[i] * $signed({1'b0, r3_cb[i][SPLIT_W-1:0]}));
                r4_hi[2][i] <= HI_W'(r3_e2[i] * $signed(r3_cb[i][CROSS_W-1:SPLIT_W]));
                r4_lo[2][i] <= LO_W'(r3_e2[i] * $signed({1'b0, r3_cb[i][SPLIT_W-1:0]}));
            end
            for (int k = 0; k < 3; k++) begin
                // stage 5: recombine halves
                for (int i = 0; i < 3; i++) begin
                    r5_t[k][i] <= (DOT_W'(r4_hi[k][i]) <<< SPLIT_W) + DOT_W'(r4_lo[k][i]);
                end
                // stage 6: dot product sums
                r6_sum[k] <= r5_t[k][0] + r5_t[k][1] + r5_t[k][2];
            end
        end
    end

    assign o_req_u = '{valid: r_v[6], num: r6_sum[0], den: r6_sum[2]};
    assign o_req_v = '{valid: r_v[6], num: r6_sum[1], den: r6_sum[2]};

endmodule

`default_nettype wire

@@ rtl/rdc_div.sv @@
// pipelined restoring divider: rounded fixed point quotient with saturation
// depends on rdc_pkg
`default_nettype none

module rdc_div #(
    parameter int FRAC_BITS = rdc_pkg::FRAC_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  rdc_pkg::t_quot_req  i_req,
    output rdc_pkg::t_div_res   o_res
);
    import rdc_pkg::*;

    localparam logic [OUT_W-1:0] LIM_POS = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] LIM_NEG = {1'b1, {(OUT_W-1){1'b0}}};

    logic             r0_valid, r0_neg, r0_zero;
    logic [MAG_W-1:0] r0_un, r0_ud;

    logic             r_b_valid [0:QB];
    logic             r_b_neg   [0:QB];
    logic             r_b_zero  [0:QB];
    logic             r_b_sat   [0:QB];
    logic [MAG_W-1:0] r_b_ud    [0:QB];
    logic [RW-1:0]    r_b_rem   [0:QB];
    logic [QB-1:0]    r_b_q     [0:QB];

    logic [QB-1:0]    w_round;
    logic [OUT_W-1:0] w_lim, w_mag;
    logic             w_over;
    t_div_res         r_res;

    // magnitudes and sign
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (i_en) begin
            r0_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_neg  <= i_req.num[DOT_W-1] ^ i_req.den[DOT_W-1];
            r0_zero <= (i_req.den == '0);
            r0_un   <= i_req.num[DOT_W-1] ? MAG_W'(-i_req.num) : MAG_W'(i_req.num);
            r0_ud   <= i_req.den[DOT_W-1] ? MAG_W'(-i_req.den) : MAG_W'(i_req.den);
        end
    end

    // overflow pre-check and dividend alignment
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_b_valid[0] <= r0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_neg[0]  <= r0_neg;
            r_b_zero[0] <= r0_zero;
            r_b_ud[0]   <= r0_ud;
            r_b_sat[0]  <= RW'(r0_un) >= (RW'(r0_ud) << (OUT_W - FRAC_BITS));
            r_b_rem[0]  <= RW'(r0_un) << (FRAC_BITS + 1);
            r_b_q[0]    <= '0;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar s = 0; s < QB; s++) begin : g_bit
        localparam int K = QB - 1 - s;
        logic [RW-1:0] w_sub;
        logic          w_ge;

        always_comb begin
            w_sub = RW'(r_b_ud[s]) << K;
            w_ge  = r_b_rem[s] >= w_sub;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_b_valid[s+1] <= 1'b0;
            end else if (i_en) begin
                r_b_valid[s+1] <= r_b_valid[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_b_neg[s+1]  <= r_b_neg[s];
                r_b_zero[s+1] <= r_b_zero[s];
                r_b_sat[s+1]  <= r_b_sat[s];
                r_b_ud[s+1]   <= r_b_ud[s];
                r_b_rem[s+1]  <= w_ge ? r_b_rem[s] - w_sub : r_b_rem[s];
                r_b_q[s+1]    <= {r_b_q[s][QB-2:0], w_ge};
            end
        end
    end

    // round half away from zero, clamp, apply sign
    always_comb begin
        w_round = QB'(({1'b0, r_b_q[QB]} + (QB+1)'(1)) >> 1);
        w_lim   = r_b_neg[QB] ? LIM_NEG : LIM_POS;
        w_over  = r_b_sat[QB] || (w_round > QB'(w_lim));
        w_mag   = w_over ? w_lim : w_round[OUT_W-1:0];
    end

    // result register; only the valid bit is cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else if (i_en) begin
            r_res.valid <= r_b_valid[QB];
            r_res.zero  <= r_b_zero[QB];
            r_res.sat   <= w_over && !r_b_zero[QB];
            if (r_b_zero[QB]) begin
                r_res.coord <= '0;
            end else begin
                r_res.coord <= r_b_neg[QB] ? -$signed(w_mag) : $signed(w_mag);
            end
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

@@ rtl/ray_to_display_coordinates_top.sv @@
// ray to display plane intersection, u/v coordinates by cramer's rule, signed q8.16 out
// pipeline: 35 register stages (6 determinant, 28 divider, 1 output register)
// throughput: one word per cycle while the skid entry is empty; an output register plus
// one skid entry lets the pipeline advance while a result waits; reset (sync, active low)
// clears all valid bits and the three corner registers; depends on rdc_pkg, rdc_geom,
// rdc_div, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ray_to_display_coordinates_top #(
    parameter int FRAC_BITS = rdc_pkg::FRAC_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // configuration write channel
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [rdc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [rdc_pkg::CFG_W-1:0]          i_cfg_data,
    // ray input channel
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire  signed [rdc_pkg::CORD_W-1:0]  i_origin_x,
    input  wire  signed [rdc_pkg::CORD_W-1:0]  i_origin_y,
    input  wire  signed [rdc_pkg::CORD_W-1:0]  i_origin_z,
    input  wire  signed [rdc_pkg::DIR_W-1:0]   i_dir_x,
    input  wire  signed [rdc_pkg::DIR_W-1:0]   i_dir_y,
    input  wire  signed [rdc_pkg::DIR_W-1:0]   i_dir_z,
    // coordinate output channel
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic signed [rdc_pkg::OUT_W-1:0]   o_coord_u,
    output logic signed [rdc_pkg::OUT_W-1:0]   o_coord_v,
    output logic                               o_degenerate,
    output logic                               o_saturated
);
    import rdc_pkg::*;

    // output range ends
    localparam logic [OUT_W-1:0] OUT_HI = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_LO = {1'b1, {(OUT_W-1){1'b0}}};

    // corner registers
    logic [CFG_W-1:0] r_ll, r_ul, r_lr;

    // pipeline stall: whole pipeline holds while the skid entry is full
    logic      w_en;
    t_quot_req w_req_u, w_req_v;
    t_div_res  w_res_u, w_res_v;
    t_out_word w_word;

    // output register and skid entry
    logic      r_out_valid, r_skid_valid;
    t_out_word r_out, r_skid;

    assign o_cfg_ready = 1'b1;

    // config writes; out-of-range index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ll <= '0;
            r_ul <= '0;
            r_lr <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LL:  r_ll <= i_cfg_data;
                REG_UL:  r_ul <= i_cfg_data;
                REG_LR:  r_lr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_en       = !r_skid_valid;
    assign o_in_ready = w_en;

    // determinants: u numerator, v numerator, shared denominator
    rdc_geom u_geom (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_in_valid),
        .i_ll       (r_ll),
        .i_ul       (r_ul),
        .i_lr       (r_lr),
        .i_origin_x (i_origin_x),
        .i_origin_y (i_origin_y),
        .i_origin_z (i_origin_z),
        .i_dir_x    (i_dir_x),
        .i_dir_y    (i_dir_y),
        .i_dir_z    (i_dir_z),
        .o_req_u    (w_req_u),
        .o_req_v    (w_req_v)
    );

    // one divider pipeline per coordinate
    rdc_div #(.FRAC_BITS(FRAC_BITS)) u_div_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_req   (w_req_u),
        .o_res   (w_res_u)
    );

    rdc_div #(.FRAC_BITS(FRAC_BITS)) u_div_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_req   (w_req_v),
        .o_res   (w_res_v)
    );

    // both dividers see the same denominator, so the zero flags agree
    assign w_word = '{coord_u:    w_res_u.coord,
                      coord_v:    w_res_v.coord,
                      degenerate: w_res_u.zero | w_res_v.zero,
                      saturated:  w_res_u.sat | w_res_v.sat};

    // output register with skid: the pipeline word leaves whenever w_en is high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_res_u.valid;
            end
        end else if (w_en && w_res_u.valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            r_out <= r_skid_valid ? r_skid : w_word;
        end else if (w_en && w_res_u.valid) begin
            r_skid <= w_word;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_coord_u    = r_out.coord_u;
    assign o_coord_v    = r_out.coord_v;
    assign o_degenerate = r_out.degenerate;
    assign o_saturated  = r_out.saturated;

    // skid only fills while the output word is held
    `RDC_ASSERT(a_skid_fill, i_clk, i_rst_n, $rose(r_skid_valid) |-> $past(r_out_valid && !i_out_ready))
    // a skid word always sits behind a valid output word
    `RDC_ASSERT(a_skid_order, i_clk, i_rst_n, r_skid_valid |-> r_out_valid)
    // degenerate plane gives zero coordinates and no clipping
    `RDC_ASSERT(a_degen_zero, i_clk, i_rst_n, (o_out_valid && o_degenerate) |-> (o_coord_u == '0 && o_coord_v == '0 && !o_saturated))
    // a clipped word has a coordinate at a range end
    `RDC_ASSERT(a_sat_range, i_clk, i_rst_n, (o_out_valid && o_saturated) |-> (o_coord_u == OUT_HI || o_coord_u == OUT_LO || o_coord_v == OUT_HI || o_coord_v == OUT_LO))

endmodule

`default_nettype wire

@@ sim/ray_to_display_coordinates_top_tb.sv @@
// self-checking testbench for ray_to_display_coordinates_top: rays in, u/v coordinates out
// predicts each result from the corner registers written, checks in order
// depends on rdc_pkg and the rtl of ray_to_display_coordinates_top
`timescale 1ns / 1ps
`default_nettype none

// expected coordinate words and the corner copy they are predicted from
class coord_scoreboard;
    logic [rdc_pkg::CFG_W-1:0] corner [3];
    rdc_pkg::t_out_word        expected_q[$];
    int                        mismatches;
    int                        checked;
    int                        degen_seen;
    int                        sat_seen;

    function new();
        foreach (corner[i]) corner[i] = '0;
        mismatches = 0;
        checked    = 0;
        degen_seen = 0;
        sat_seen   = 0;
    endfunction

    // writes to the unused index are dropped, as in the block
    function void write_corner(logic [rdc_pkg::CFG_IDX_W-1:0] idx,
                               logic [rdc_pkg::CFG_W-1:0] data);
        if (idx == rdc_pkg::REG_LL || idx == rdc_pkg::REG_UL || idx == rdc_pkg::REG_LR)
            corner[idx] = data;
    endfunction

    // determinant with columns a, b, c
    function longint det3(longint a[3], longint b[3], longint c[3]);
        longint x, y, z;
        x = b[1] * c[2] - b[2] * c[1];
        y = b[2] * c[0] - b[0] * c[2];
        z = b[0] * c[1] - b[1] * c[0];
        return a[0] * x + a[1] * y + a[2] * z;
    endfunction

    // round-half-away quotient of num * 2^16 / den, clipped to 24 bits
    function longint fixed_quot(longint num, longint den, inout bit sat);
        bit          neg;
        logic [63:0] un, ud, q, r, lim;
        neg = (num < 0) != (den < 0);
        un  = (num < 0) ? -num : num;
        ud  = (den < 0) ? -den : den;
        lim = neg ? 64'd8388608 : 64'd8388607;
        q   = un / ud;
        r   = un % ud;
        if (q > lim) begin
            sat = 1'b1;
            q   = lim;
        end else begin
            for (int i = 0; i < rdc_pkg::FRAC_BITS_DEF; i++) begin
                q = q << 1;
                r = r << 1;
                if (r >= ud) begin
                    r = r - ud;
                    q[0] = 1'b1;
                end
            end
            if ((r << 1) >= ud) q = q + 1;
            if (q > lim) begin
                sat = 1'b1;
                q   = lim;
            end
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function void note_ray(logic [19:0] ox, logic [19:0] oy, logic [19:0] oz,
                           logic [17:0] dx, logic [17:0] dy, logic [17:0] dz);
        longint             ll[3], ul[3], lr[3], e2[3], e3[3], p[3], d[3];
        longint             den, u, v;
        logic [19:0]        org[3];
        logic [17:0]        dir[3];
        bit                 sat;
        rdc_pkg::t_out_word w;
        org = '{ox, oy, oz};
        dir = '{dx, dy, dz};
        sat = 1'b0;
        u   = 0;
        v   = 0;
        for (int i = 0; i < 3; i++) begin
            ll[i] = longint'($signed(corner[0][20*i +: 20]));
            ul[i] = longint'($signed(corner[1][20*i +: 20]));
            lr[i] = longint'($signed(corner[2][20*i +: 20]));
            e2[i] = ul[i] - ll[i];
            e3[i] = lr[i] - ll[i];
            p[i]  = longint'($signed(org[i])) - ll[i];
            d[i]  = longint'($signed(dir[i]));
        end
        den = det3(e2, e3, d);
        if (den != 0) begin
            u = fixed_quot(det3(e2, p, d), den, sat);
            v = fixed_quot(det3(p, e3, d), den, sat);
        end
        w.coord_u    = u[23:0];
        w.coord_v    = v[23:0];
        w.degenerate = (den == 0);
        w.saturated  = sat;
        expected_q.insert(expected_q.size(), w);
    endfunction

    function void check_result(rdc_pkg::t_out_word got);
        rdc_pkg::t_out_word want;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected word u=%0d v=%0d deg=%0b sat=%0b",
                         got.coord_u, got.coord_v, got.degenerate, got.saturated);
            return;
        end
        want = expected_q.pop_front();
        checked++;
        if (want.degenerate) degen_seen++;
        if (want.saturated) sat_seen++;
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch word %0d: exp u=%0d v=%0d deg=%0b sat=%0b, got u=%0d v=%0d deg=%0b sat=%0b",
                         checked, want.coord_u, want.coord_v, want.degenerate,
                         want.saturated, got.coord_u, got.coord_v, got.degenerate,
                         got.saturated);
        end
    endfunction
endclass

module ray_to_display_coordinates_top_tb;
    import rdc_pkg::*;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
    localparam int ONE       = 65536;
    localparam int CORD_MAX  = 524287;
    localparam int CORD_MIN  = -524288;
    localparam int DRAIN_GAP = 40;       // drain margin beyond the pipeline depth
    localparam int LIMIT     = 600000;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [CFG_W-1:0]            i_cfg_data = '0;
    logic                        i_in_valid = 1'b0;
    logic signed [CORD_W-1:0]    i_origin_x = '0, i_origin_y = '0, i_origin_z = '0;
    logic signed [DIR_W-1:0]     i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic                        i_out_ready = 1'b0;
    wire                         o_cfg_ready, o_in_ready, o_out_valid;
    wire                         o_degenerate, o_saturated;
    wire signed [OUT_W-1:0]      o_coord_u, o_coord_v;

    coord_scoreboard sb = new();

    // idling control: bursts on both sides unless quiet, long receiver hold on request
    bit idle_on   = 1'b1;
    int hold_left = 0;
    int cycles    = 0;
    int rays_sent = 0;
    int phases    = 0;

    ray_to_display_coordinates_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_origin_x   (i_origin_x),
        .i_origin_y   (i_origin_y),
        .i_origin_z   (i_origin_z),
        .i_dir_x      (i_dir_x),
        .i_dir_y      (i_dir_y),
        .i_dir_z      (i_dir_z),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_coord_u    (o_coord_u),
        .o_coord_v    (o_coord_v),
        .o_degenerate (o_degenerate),
        .o_saturated  (o_saturated)
    );

    always #10 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("ray_to_display_coordinates_top verification failed");
            $finish;
        end
    end

    // receiver ready: long hold first, then random stall bursts, else always ready
    initial begin
        int burst;
        burst = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready = 1'b0;
            end else if (!idle_on) begin
                i_out_ready = 1'b1;
            end else if (burst > 0) begin
                burst--;
                i_out_ready = 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 6) - 1;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    // result monitor, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result('{o_coord_u, o_coord_v, o_degenerate, o_saturated});
    end

    function automatic logic [CFG_W-1:0] pack_corner(int x, int y, int z);
        logic [19:0] fx, fy, fz;
        fx = x[19:0];
        fy = y[19:0];
        fz = z[19:0];
        return {fz, fy, fx};
    endfunction

    // all tasks below start and end at a falling edge
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_corner(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_ray(int ox, int oy, int oz, int dx, int dy, int dz);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_origin_x = ox[19:0];
        i_origin_y = oy[19:0];
        i_origin_z = oz[19:0];
        i_dir_x    = dx[17:0];
        i_dir_y    = dy[17:0];
        i_dir_z    = dz[17:0];
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_ray(i_origin_x, i_origin_y, i_origin_z, i_dir_x, i_dir_y, i_dir_z);
        rays_sent++;
        @(negedge i_clk);
    endtask

    // random ray; mostly unit-range directions from origins within four units, some raw bit noise
    task automatic send_random_ray();
        int ox, oy, oz, dx, dy, dz;
        if ($urandom_range(0, 9) == 0) begin
            ox = $urandom; oy = $urandom; oz = $urandom;
            dx = $urandom; dy = $urandom; dz = $urandom;
        end else begin
            ox = $urandom_range(0, 2 * ONE * 4) - ONE * 4;
            oy = $urandom_range(0, 2 * ONE * 4) - ONE * 4;
            oz = $urandom_range(0, 2 * ONE * 4) - ONE * 4;
            dx = $urandom_range(0, 2 * ONE) - ONE;
            dy = $urandom_range(0, 2 * ONE) - ONE;
            dz = $urandom_range(0, 2 * ONE) - ONE;
        end
        send_ray(ox, oy, oz, dx, dy, dz);
    endtask

    // stop offering and wait for every expected word, plus the pipeline depth
    task automatic drain();
        i_in_valid = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_GAP) @(negedge i_clk);
    endtask

    task automatic random_corners();
        int c[9];
        foreach (c[i]) c[i] = $urandom_range(0, 2 * ONE * 3) - ONE * 3;
        write_reg(REG_LL, pack_corner(c[0], c[1], c[2]));
        write_reg(REG_UL, pack_corner(c[3], c[4], c[5]));
        write_reg(REG_LR, pack_corner(c[6], c[7], c[8]));
        phases++;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // corners still zero after reset: every ray is degenerate
        send_ray(ONE, ONE, ONE, 0, 0, -ONE);
        send_ray(CORD_MIN, CORD_MAX, 0, -131072, 131071, 1);
        drain();

        // unit square in the z = 0 plane
        write_reg(REG_LL, pack_corner(0, 0, 0));
        write_reg(REG_UL, pack_corner(0, ONE, 0));
        write_reg(REG_LR, pack_corner(ONE, 0, 0));
        // the unused index must leave the corners alone
        write_reg(REG_NONE, {CFG_W{1'b1}});
        phases++;
        send_ray(ONE / 2, ONE / 4, ONE, 0, 0, -ONE);
        send_ray(-ONE / 2, -3 * ONE, -ONE, 0, 0, ONE);
        send_ray(1, 3, ONE, 0, 0, -ONE);
        send_ray(-1, -3, ONE, ONE / 2, 0, -ONE / 2);
        send_ray(ONE, ONE, ONE, 3, 7, 2);                  // near-parallel, tie candidates
        send_ray(CORD_MAX, CORD_MAX, CORD_MAX, 0, 0, -1);  // largest origin, coordinates still in range
        send_ray(CORD_MIN, CORD_MIN, CORD_MAX, 0, 0, -1);  // most negative origin, coordinates still in range
        send_ray(CORD_MAX, CORD_MIN, CORD_MIN, ONE, ONE, 0); // parallel to plane
        send_ray(0, 0, 0, 0, 0, 0);                        // zero direction
        send_ray(ONE, 0, ONE, 131071, -131072, 131071);    // direction outside unit range
        send_ray(ONE, ONE, 2 * ONE, -131072, 131071, -131072);
        send_ray(CORD_MIN, CORD_MAX, CORD_MIN, -ONE, ONE, ONE);
        drain();

        // extreme corners: widest plane the fields allow
        write_reg(REG_LL, pack_corner(CORD_MIN, CORD_MIN, CORD_MIN));
        write_reg(REG_UL, pack_corner(CORD_MIN, CORD_MAX, CORD_MIN));
        write_reg(REG_LR, pack_corner(CORD_MAX, CORD_MIN, CORD_MIN));
        phases++;
        send_ray(CORD_MAX, CORD_MAX, CORD_MAX, 0, 0, -ONE);
        send_ray(CORD_MIN, CORD_MIN, CORD_MAX, ONE, -ONE, -1);
        send_ray(0, 0, 0, -131072, -131072, -131072);
        send_ray(CORD_MAX, CORD_MIN, 0, 131071, 131071, 131071);
        for (int i = 0; i < 40; i++) send_random_ray();
        drain();

        // raw bit patterns in every register
        write_reg(REG_LL, {CFG_W{1'b1}});
        write_reg(REG_UL, CFG_W'({$urandom, $urandom}));
        write_reg(REG_LR, CFG_W'({$urandom, $urandom}));
        phases++;
        for (int i = 0; i < 60; i++) send_random_ray();
        drain();

        // receiver holds off while the sender keeps offering: block fills and stalls input
        random_corners();
        hold_left = 300;
        for (int i = 0; i < 120; i++) send_random_ray();
        drain();

        // several random planes with bursty idling on both sides
        for (int ph = 0; ph < 5; ph++) begin
            random_corners();
            for (int i = 0; i < 100; i++) send_random_ray();
            drain();
        end

        // last part: no idling, back to back
        idle_on = 1'b0;
        random_corners();
        for (int i = 0; i < 100; i++) send_random_ray();
        drain();

        $display("%0d rays over %0d corner settings, %0d words checked (%0d degenerate, %0d clipped)",
                 rays_sent, phases, sb.checked, sb.degen_seen, sb.sat_seen);
        if (sb.mismatches != 0)
            $display("%0d mismatching words", sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("ray_to_display_coordinates_top verification clean");
        end else begin
            $display("ray_to_display_coordinates_top verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
